// ===== sv/huffman_code_bit_packer_unit_defines.svh =====
// Assertion helpers for the prefix-code bit packer.
// Each macro expects i_clk and i_rst_n in scope and is silent during reset.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/hcbp_pkg.sv =====
package hcbp_pkg;

    // Command codes carried on the request side tuser.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 6;
    localparam int PEND_W = 7;
    localparam int CNT_W  = 3;
    localparam int SYM_W  = 8;
    localparam int CMD_W  = 2;

    // Request tdata: symbol, code word, code length, zero padding.
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    typedef logic [CMD_W-1:0] t_cmd;

endpackage

// ===== sv/hcbp_emit.sv =====
module hcbp_emit #(
    parameter int ACC_W = 39,
    localparam int NB = ACC_W / 8,
    localparam int IW = (NB > 1) ? $clog2(NB) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [ACC_W-1:0]         i_data,
    input  logic [IW-1:0]            i_last_idx,
    output logic                     o_free,
    output logic                     o_valid,
    output logic [hcbp_pkg::BYTE_W-1:0] o_byte,
    output logic                     o_last,
    input  logic                     i_ready
);
    import hcbp_pkg::*;

    logic             r_valid;
    logic [IW-1:0]    r_idx;
    logic [ACC_W-1:0] r_data;
    logic             take;

    // Bytes are right aligned in r_data; the highest one goes out first.
    assign take    = r_valid && i_ready;
    assign o_valid = r_valid;
    assign o_last  = (r_idx == '0);
    assign o_byte  = BYTE_W'(r_data >> {r_idx, 3'b000});
    assign o_free  = !r_valid || (take && (r_idx == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= i_last_idx;
        end else if (take) begin
            if (r_idx == '0) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== sv/huffman_code_bit_packer_unit.sv =====
// Channel    Dir  Handshake                         Payload
// s_axis     in   s_axis_tvalid / s_axis_tready     tuser: cmd; tdata: symbol, code_bits,
//                                                   code_length
// m_axis     out  m_axis_tvalid / m_axis_tready     tdata: out_byte; tlast: last
//
// A request is taken every cycle while the pipeline moves; load, encode and flush each
// use a single request. An encode that completes n bytes (up to (7 + MAX_CODE_LEN) / 8)
// holds the byte emitter until they are sent, one byte per cycle while m_axis_tready is high,
// so the sustained rate is set by the single output byte lane. The code table read is
// registered. Reset (synchronous, active low) clears the pending bits and the pipeline;
// the code table is not cleared and must be loaded before use. A stalled output first
// fills the emitter, then holds the combine stage, then drops s_axis_tready.
module huffman_code_bit_packer_unit #(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
    input  logic [hcbp_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // tuser: [1:0] cmd
    input  logic [hcbp_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [7:0] out_byte
    output logic [hcbp_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast
);
    import hcbp_pkg::*;

`include "huffman_code_bit_packer_unit_defines.svh"

    // Accumulator holds the pending bits followed by the longest code word.
    localparam int AW      = $clog2(SYMBOLS);
    localparam int ACC_W   = PEND_W + MAX_CODE_LEN;
    localparam int NB      = ACC_W / 8;
    localparam int IW      = (NB > 1) ? $clog2(NB) : 1;
    localparam int TW      = $clog2(ACC_W + 1);
    localparam int ENTRY_W = WORD_W + LEN_W;

    // Request fields.
    t_cmd              in_cmd;
    logic [SYM_W-1:0]  in_sym;
    logic [WORD_W-1:0] in_bits;
    logic [LEN_W-1:0]  in_len;
    logic              in_take;
    logic              in_sym_ok;

    assign in_cmd    = s_axis_tuser;
    assign in_sym    = s_axis_tdata[7:0];
    assign in_bits   = s_axis_tdata[39:8];
    assign in_len    = s_axis_tdata[45:40];
    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign in_sym_ok = (32'(in_sym) < SYMBOLS);

    // Loads saturate the length and drop code bits above it before writing.
    logic [LEN_W-1:0]  wr_len;
    logic [WORD_W-1:0] wr_word;

    assign wr_len  = (32'(in_len) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : in_len;
    assign wr_word = in_bits & ~({WORD_W{1'b1}} << wr_len);

    // Code table: one write port for loads, one registered read port for encodes.
    // Both act at the accept edge, so an encode right after a load of the same
    // symbol already sees the new entry.
    logic [ENTRY_W-1:0] r_table [SYMBOLS];
    logic [ENTRY_W-1:0] r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (in_take && in_sym_ok && (in_cmd == CMD_LOAD)) begin
            r_table[in_sym[AW-1:0]] <= {wr_len, wr_word};
        end
        if (in_take && in_sym_ok && (in_cmd == CMD_ENCODE)) begin
            r_rd_entry <= r_table[in_sym[AW-1:0]];
        end
    end

    // Combine stage: holds one encode or flush while the table data arrives.
    logic r_s1_valid;
    logic r_s1_flush;

    // Pending partial byte, right aligned.
    logic [PEND_W-1:0] r_pend_bits;
    logic [CNT_W-1:0]  r_pend_cnt;
    logic [PEND_W-1:0] n_pend_bits;
    logic [CNT_W-1:0]  n_pend_cnt;

    logic [WORD_W-1:0] rd_word;
    logic [LEN_W-1:0]  rd_len;
    logic [ACC_W-1:0]  acc;
    logic [TW-1:0]     total;
    logic [CNT_W-1:0]  rem;
    logic [TW-1:0]     nbytes;
    logic [ACC_W-1:0]  full;
    logic [ACC_W-1:0]  em_data;
    logic [IW-1:0]     em_last_idx;
    logic              s1_emits;
    logic              s1_go;
    logic              em_free;
    logic              em_load;

    assign rd_word = r_rd_entry[WORD_W-1:0];
    assign rd_len  = r_rd_entry[ENTRY_W-1:WORD_W];

    // Append the code word after the pending bits; whole bytes sit above the
    // leftover bits, which become the new pending byte.
    assign acc    = (ACC_W'(r_pend_bits) << rd_len) | ACC_W'(rd_word);
    assign total  = TW'(r_pend_cnt) + TW'(rd_len);
    assign rem    = total[CNT_W-1:0];
    assign nbytes = total >> 3;
    assign full   = acc >> rem;

    always_comb begin
        if (r_s1_flush) begin
            // The partial byte goes out padded with zeros at the bottom.
            em_data     = ACC_W'(BYTE_W'({1'b0, r_pend_bits} << (4'd8 - 4'(r_pend_cnt))));
            em_last_idx = '0;
            s1_emits    = (r_pend_cnt != '0);
            n_pend_bits = '0;
            n_pend_cnt  = '0;
        end else begin
            em_data     = full;
            em_last_idx = IW'(nbytes - 1'b1);
            s1_emits    = (nbytes != '0);
            n_pend_bits = PEND_W'(acc) & ~({PEND_W{1'b1}} << rem);
            n_pend_cnt  = rem;
        end
    end

    // The stage moves on when it has nothing to emit or the emitter can take it.
    assign s1_go         = r_s1_valid && (!s1_emits || em_free);
    assign em_load       = s1_go && s1_emits;
    assign s_axis_tready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_flush  <= 1'b0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            if (s1_go) begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
            end
            if (in_take) begin
                // Loads, out-of-range symbols and the unused command end here.
                r_s1_valid <= ((in_cmd == CMD_ENCODE) && in_sym_ok) || (in_cmd == CMD_FLUSH);
                r_s1_flush <= (in_cmd == CMD_FLUSH);
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Byte emitter doubles as the output register, so a new request can be
    // combined while earlier bytes are still waiting on the output.
    hcbp_emit #(
        .ACC_W (ACC_W)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (em_load),
        .i_data     (em_data),
        .i_last_idx (em_last_idx),
        .o_free     (em_free),
        .o_valid    (m_axis_tvalid),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .i_ready    (m_axis_tready)
    );

    // A flush always leaves nothing pending.
    `HCBP_ASSERT_NEXT(a_flush_clears, s1_go && r_s1_flush, r_pend_cnt == '0, "flush left bits")

    // A flush with pending bits must put a byte on the output.
    `HCBP_ASSERT_NEXT(a_flush_emits, em_load && r_s1_flush, m_axis_tvalid, "no flush byte")

    // A held combine stage must block new requests.
    `HCBP_ASSERT_NOW(a_stall_blocks, r_s1_valid && !s1_go, !s_axis_tready, "taken while held")

endmodule
